>>> src/fuel_level_gauge_filter_core_macros.svh
// assertion macros shared by the fuel gauge filter rtl
// expects clk and rst in the scope where a macro is used

`ifndef FUEL_LEVEL_GAUGE_FILTER_CORE_MACROS_SVH
`define FUEL_LEVEL_GAUGE_FILTER_CORE_MACROS_SVH

// condition that holds at every clock edge out of reset
`define FGF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define FGF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/fgf_pkg.sv
// shared types and constants of the fuel gauge filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fgf_pkg;

  // field widths
  localparam int unsigned ADC_CODE_W = 10;
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned LITRES_W   = 7;
  localparam int unsigned STATE_W    = 32;

  // shared divider: dividend bits and divisor / remainder bits
  localparam int unsigned NUM_W  = 27;
  localparam int unsigned DEN_W  = 18;
  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  // sender resistance in q9.8 ohms
  localparam int unsigned R_W         = 17;
  localparam int unsigned SERIES_OHMS = 330;
  localparam logic [R_W-1:0] R_CLAMP_LOW  = R_W'(35 * 256);
  localparam logic [R_W-1:0] R_CLAMP_HIGH = R_W'(265 * 256);

  localparam logic [LITRES_W-1:0] LITRES_MAX = LITRES_W'(99);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ALPHA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TREND_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TANK_LITRES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd5;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PRELOAD,
    OP_SAMPLE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SUM_W-1:0] data;   // code for a sample, priming sum for a preload
  } q_entry_t;

  typedef struct packed {
    logic [9:0]  empty_resistance_low;
    logic [9:0]  empty_resistance_high;
    logic [15:0] level_alpha;
    logic [15:0] trend_alpha;
    logic [7:0]  tank_litres;
    logic [31:0] consumption_period;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DEN_W-1:0]  rem_init;
    logic [NUM_W-1:0]  num;      // left aligned, msb first
    logic [STEP_W-1:0] steps;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [FRAC_W-1:0]   consumption_rate;
    logic [LITRES_W-1:0] litres;
    logic [FRAC_W-1:0]   level_fraction;
    logic                consumption_updated;
  } res_t;

endpackage

>>> src/fuel_level_gauge_filter_core.sv
// top level of the fuel gauge filter: ports, configuration registers, wiring
// depends on fgf_pkg, fgf_front, fgf_queue, fgf_div, fgf_back and the macros header
`timescale 1ns / 1ps

// Filtered fuel level from a resistive sender. Input items are either adc
// samples or millisecond ticks (s_tuser high). A tick is handled in the idle
// state of the back end and gives no result. The first PRIME_SAMPLES samples
// are only summed in the front end; the last of them gives one result
// carrying the preloaded level. Every later sample gives one result with the
// fast level, litres, the consumption rate and a flag when a new consumption
// snapshot was taken. In the back end a sample is taken from the queue and
// range checked, then runs both passes of the shared bit-serial divider, the
// 27 step sender resistance pass and the 16 step full-fraction pass, then
// the two filters, the snapshot, the litres product and the output register.
// The full-scale code skips the resistance pass and a clamped fraction skips
// the fraction pass. The preload divides its sum by the priming count with a
// reciprocal multiply and skips the filters.
// A result waiting in the output register holds the back end until taken.
// A four entry queue lets the input side keep taking items while the back
// end works and while a result waits in the output register. There is no
// memory and no clearing pass after reset.
// Configuration writes must only happen while the block is idle.

module fuel_level_gauge_filter_core #(
  parameter int unsigned PRIME_SAMPLES = 100,
  parameter int unsigned ADC_BITS      = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,   // [9:0] adc_code, rest zero
  input  logic                              s_tuser,   // [0] kind, high for a tick
  // result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata,   // [15:0] level_fraction,
                                                       // [22:16] litres,
                                                       // [38:23] consumption_rate
  output logic                              m_tuser,   // [0] consumption_updated
  // configuration writes
  input  logic                              cfg_we,
  input  logic [fgf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fgf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fgf_pkg::*;

  `include "fuel_level_gauge_filter_core_macros.svh"

  cfg_t              cfg;
  logic              q_room;
  logic              push_valid;
  q_entry_t          push_entry;
  logic              head_valid;
  q_entry_t          head;
  logic              pop;
  logic [QCNT_W-1:0] q_count;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  res_t              res;

  // configuration register file, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.empty_resistance_low  <= 10'd35;
      cfg.empty_resistance_high <= 10'd265;
      cfg.level_alpha           <= 16'd66;
      cfg.trend_alpha           <= 16'd7;
      cfg.tank_litres           <= 8'd60;
      cfg.consumption_period    <= 32'd1800000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EMPTY_LOW:   cfg.empty_resistance_low  <= cfg_data[9:0];
        CFG_EMPTY_HIGH:  cfg.empty_resistance_high <= cfg_data[9:0];
        CFG_LEVEL_ALPHA: cfg.level_alpha           <= cfg_data[15:0];
        CFG_TREND_ALPHA: cfg.trend_alpha           <= cfg_data[15:0];
        CFG_TANK_LITRES: cfg.tank_litres           <= cfg_data[7:0];
        CFG_PERIOD:      cfg.consumption_period    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // front: takes every item while the queue has room, absorbs priming samples
  fgf_front #(
    .PRIME_SAMPLES(PRIME_SAMPLES),
    .ADC_BITS     (ADC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .adc_code  (s_tdata[ADC_CODE_W-1:0]),
    .kind      (s_tuser),
    .q_room    (q_room),
    .push_valid(push_valid),
    .push_entry(push_entry)
  );

  fgf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_entry(push_entry),
    .room      (q_room),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .count     (q_count)
  );

  fgf_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // back: one item at a time, result held in its output register
  fgf_back #(
    .PRIME_SAMPLES(PRIME_SAMPLES),
    .ADC_BITS     (ADC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (head_valid),
    .q_head   (head),
    .q_pop    (pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .res_valid(m_tvalid),
    .res      (res),
    .res_ready(m_tready)
  );

  assign m_tdata = {1'b0, res.consumption_rate, res.litres, res.level_fraction};
  assign m_tuser = res.consumption_updated;

  // queue occupancy never passes its depth
  `FGF_ASSERT_ALWAYS(a_queue_bound, q_count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  // front only pushes into a queue with a free slot
  `FGF_ASSERT_IMPLIES(a_push_room, push_valid, q_count < QCNT_W'(QUEUE_DEPTH), "full queue")
  // litres in a presented result stays within its clamp
  `FGF_ASSERT_IMPLIES(a_litres_clamp, m_tvalid, m_tdata[22:16] <= LITRES_MAX, "litres above clamp")

endmodule

>>> src/fgf_front.sv
// front end: accepts items, keeps the priming accumulator, classifies
// depends on fgf_pkg
`timescale 1ns / 1ps

module fgf_front #(
  parameter int unsigned PRIME_SAMPLES = 100,
  parameter int unsigned ADC_BITS      = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fgf_pkg::ADC_CODE_W-1:0] adc_code,
  input  logic                          kind,
  input  logic                          q_room,
  output logic                          push_valid,
  output fgf_pkg::q_entry_t             push_entry
);
  import fgf_pkg::*;

  localparam int unsigned CNT_W = $clog2(PRIME_SAMPLES + 1);
  localparam int unsigned MASK_INT = (ADC_BITS >= ADC_CODE_W) ?
                                     (1 << ADC_CODE_W) - 1 : (1 << ADC_BITS) - 1;
  localparam logic [ADC_CODE_W-1:0] CODE_MASK = ADC_CODE_W'(MASK_INT);

  logic             primed;
  logic [CNT_W-1:0] prime_count;
  logic [SUM_W-1:0] prime_sum;

  logic                  accept;
  logic [ADC_CODE_W-1:0] v;
  logic [SUM_W-1:0]      sum_next;
  logic                  last_prime;

  always_comb begin
    s_tready   = q_room;
    accept     = s_tvalid && q_room;
    v          = adc_code & CODE_MASK;
    sum_next   = prime_sum + SUM_W'(v);
    last_prime = (prime_count == CNT_W'(PRIME_SAMPLES - 1));
    push_valid = accept && (kind || primed || last_prime);
    if (kind) begin
      push_entry.op   = OP_TICK;
      push_entry.data = '0;
    end else if (primed) begin
      push_entry.op   = OP_SAMPLE;
      push_entry.data = SUM_W'(v);
    end else begin
      push_entry.op   = OP_PRELOAD;
      push_entry.data = sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed      <= 1'b0;
      prime_count <= '0;
      prime_sum   <= '0;
    end else if (accept && !kind && !primed) begin
      prime_sum <= sum_next;
      if (last_prime) begin
        primed <= 1'b1;
      end else begin
        prime_count <= prime_count + CNT_W'(1);
      end
    end
  end

endmodule

>>> src/fgf_queue.sv
// short fifo of classified items between front and back
// depends on fgf_pkg
`timescale 1ns / 1ps

module fgf_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push_valid,
  input  fgf_pkg::q_entry_t         push_entry,
  output logic                      room,
  output logic                      head_valid,
  output fgf_pkg::q_entry_t         head,
  input  logic                      pop,
  output logic [fgf_pkg::QCNT_W-1:0] count
);
  import fgf_pkg::*;

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign room       = (count < QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push_valid, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/fgf_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on fgf_pkg
`timescale 1ns / 1ps

module fgf_div (
  input  logic              clk,
  input  logic              rst,
  input  fgf_pkg::div_req_t req,
  output fgf_pkg::div_rsp_t rsp
);
  import fgf_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  shift;
  logic [NUM_W-1:0]  quo;

  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial = {rem, shift[NUM_W-1]};
    qbit  = (trial >= {1'b0, den});
    if (qbit) begin
      rem_next = DEN_W'(trial - {1'b0, den});
    end else begin
      rem_next = trial[DEN_W-1:0];
    end
  end

  assign rsp = {done, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse after the last step
      done <= busy && !req.start && (cnt == STEP_W'(1));
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= req.steps;
        rem   <= req.rem_init;
        den   <= req.den;
        shift <= req.num;
        quo   <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        shift <= {shift[NUM_W-2:0], 1'b0};
        quo   <= {quo[NUM_W-2:0], qbit};
        cnt   <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/fgf_back.sv
// back end: conversion, level mapping, both filters, consumption, output register
// depends on fgf_pkg; drives the shared divider fgf_div
`timescale 1ns / 1ps

module fgf_back #(
  parameter int unsigned PRIME_SAMPLES = 100,
  parameter int unsigned ADC_BITS      = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  fgf_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  fgf_pkg::q_entry_t q_head,
  output logic              q_pop,
  output fgf_pkg::div_req_t div_req,
  input  fgf_pkg::div_rsp_t div_rsp,
  output logic              res_valid,
  output fgf_pkg::res_t     res,
  input  logic              res_ready
);
  import fgf_pkg::*;

  localparam logic [DEN_W-1:0] ADC_MAX = DEN_W'((32'd1 << ADC_BITS) - 32'd1);
  localparam int unsigned RV_W = NUM_W - 8;

  // priming average by reciprocal multiply, exact for every sum below 2^SUM_W
  localparam int unsigned AVG_SHIFT = SUM_W + $clog2(PRIME_SAMPLES);
  localparam int unsigned RECIP_W   = SUM_W + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(PRIME_SAMPLES) - 64'd1) / 64'(PRIME_SAMPLES));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIV_R,
    ST_MAP,
    ST_DIV_P,
    ST_APPLY,
    ST_DIFF,
    ST_MUL,
    ST_UPD,
    ST_SNAP,
    ST_LITRES,
    ST_EMIT
  } st_t;

  st_t state;
  logic                  is_pre;
  logic [ADC_CODE_W-1:0] v;
  logic [R_W-1:0]        r;
  logic [FRAC_W-1:0]     frac;
  logic                  sel;
  logic                  up;
  logic [STATE_W-1:0]    diff;
  logic [STATE_W+15:0]   prod;
  logic [23:0]           lit_prod;
  logic                  updated;

  logic [STATE_W-1:0] fast_level;
  logic [STATE_W-1:0] slow_trend;
  logic [FRAC_W-1:0]  trend_snapshot;
  logic [FRAC_W-1:0]  consumption_value;
  logic [31:0]        elapsed_ticks;

  // combinational helpers
  logic [RV_W-1:0]          rv;
  logic [DEN_W-1:0]         lo;
  logic [DEN_W-1:0]         hi;
  logic [DEN_W-1:0]         r_ext;
  logic [DEN_W-1:0]         map_num;
  logic [DEN_W-1:0]         map_den;
  logic [STATE_W-1:0]       x_ext;
  logic [STATE_W-1:0]       st_cur;
  logic [15:0]              alpha;
  logic [STATE_W-1:0]       delta;
  logic [FRAC_W-1:0]        trend_now;
  logic [FRAC_W:0]          drop2;
  logic [SUM_W+RECIP_W-1:0] avg_prod;
  logic [ADC_CODE_W-1:0]    prime_avg;
  logic                     div_go;

  always_comb begin
    rv        = RV_W'(v) * RV_W'(SERIES_OHMS);
    lo        = {cfg.empty_resistance_low, 8'b0};
    hi        = {cfg.empty_resistance_high, 8'b0};
    r_ext     = DEN_W'(r);
    map_num   = r_ext - lo;
    map_den   = hi - lo;
    x_ext     = {frac, 16'b0};
    st_cur    = sel ? slow_trend : fast_level;
    alpha     = sel ? cfg.trend_alpha : cfg.level_alpha;
    delta     = prod[STATE_W+15:16];
    trend_now = slow_trend[STATE_W-1:16];
    drop2     = {trend_snapshot - trend_now, 1'b0};
    avg_prod  = q_head.data * AVG_RECIP;
    prime_avg = avg_prod[AVG_SHIFT +: ADC_CODE_W];
    q_pop     = (state == ST_IDLE) && q_valid;
    // a divider pass starts where no shortcut applies
    case (state)
      ST_CONV: div_go = (DEN_W'(v) < ADC_MAX);
      ST_MAP:  div_go = (hi > lo) && (r_ext > lo) && (map_num < map_den);
      default: div_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      div_req.start     <= 1'b0;
      res_valid         <= 1'b0;
      fast_level        <= '0;
      slow_trend        <= '0;
      trend_snapshot    <= '0;
      consumption_value <= '0;
      elapsed_ticks     <= '0;
    end else begin
      div_req.start <= div_go;
      if (res_valid && res_ready && (state != ST_EMIT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_head.op)
              OP_TICK: begin
                if (elapsed_ticks != '1) begin
                  elapsed_ticks <= elapsed_ticks + 32'd1;
                end
              end
              OP_PRELOAD: begin
                is_pre <= 1'b1;
                v      <= prime_avg;
                state  <= ST_CONV;
              end
              OP_SAMPLE: begin
                is_pre <= 1'b0;
                v      <= q_head.data[ADC_CODE_W-1:0];
                state  <= ST_CONV;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_CONV: begin
          // full-scale code means an open sender: empty
          if (DEN_W'(v) >= ADC_MAX) begin
            r     <= R_CLAMP_HIGH;
            state <= ST_MAP;
          end else begin
            div_req.rem_init <= '0;
            div_req.num      <= {rv, 8'b0};
            div_req.steps    <= STEP_W'(NUM_W);
            div_req.den      <= ADC_MAX - DEN_W'(v);
            state            <= ST_DIV_R;
          end
        end
        ST_DIV_R: begin
          if (div_rsp.done) begin
            if (div_rsp.quo < NUM_W'(R_CLAMP_LOW)) begin
              r <= R_CLAMP_LOW;
            end else if (div_rsp.quo > NUM_W'(R_CLAMP_HIGH)) begin
              r <= R_CLAMP_HIGH;
            end else begin
              r <= div_rsp.quo[R_W-1:0];
            end
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (hi <= lo) begin
            frac  <= '0;
            state <= ST_APPLY;
          end else if (r_ext <= lo) begin
            frac  <= '1;
            state <= ST_APPLY;
          end else if (map_num >= map_den) begin
            frac  <= '0;
            state <= ST_APPLY;
          end else begin
            div_req.rem_init <= map_num;
            div_req.num      <= '0;
            div_req.steps    <= STEP_W'(FRAC_W);
            div_req.den      <= map_den;
            state            <= ST_DIV_P;
          end
        end
        ST_DIV_P: begin
          if (div_rsp.done) begin
            if (div_rsp.quo[FRAC_W-1:0] == '0) begin
              frac <= '1;
            end else begin
              frac <= FRAC_W'(0) - div_rsp.quo[FRAC_W-1:0];
            end
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (is_pre) begin
            fast_level <= x_ext;
            slow_trend <= x_ext;
            updated    <= 1'b0;
            state      <= ST_LITRES;
          end else begin
            sel   <= 1'b0;
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          if (x_ext >= st_cur) begin
            diff <= x_ext - st_cur;
            up   <= 1'b1;
          end else begin
            diff <= st_cur - x_ext;
            up   <= 1'b0;
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= diff * alpha;
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (sel) begin
            slow_trend <= up ? slow_trend + delta : slow_trend - delta;
            state      <= ST_SNAP;
          end else begin
            fast_level <= up ? fast_level + delta : fast_level - delta;
            sel        <= 1'b1;
            state      <= ST_DIFF;
          end
        end
        ST_SNAP: begin
          if (elapsed_ticks > cfg.consumption_period) begin
            if (trend_snapshot > trend_now) begin
              consumption_value <= drop2[FRAC_W] ? '1 : drop2[FRAC_W-1:0];
            end else begin
              consumption_value <= '0;
            end
            trend_snapshot <= trend_now;
            elapsed_ticks  <= '0;
            updated        <= 1'b1;
          end else begin
            updated <= 1'b0;
          end
          state <= ST_LITRES;
        end
        ST_LITRES: begin
          lit_prod <= fast_level[STATE_W-1:16] * cfg.tank_litres;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_valid || res_ready) begin
            res_valid               <= 1'b1;
            res.level_fraction      <= fast_level[STATE_W-1:16];
            res.litres              <= (lit_prod[23:16] > 8'(LITRES_MAX)) ?
                                       LITRES_MAX : lit_prod[22:16];
            res.consumption_rate    <= consumption_value;
            res.consumption_updated <= updated;
            state                   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
